FILE: design/tgf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tetrahedron geometric factor pipeline.
// No dependencies.
package tgf_pkg;

	localparam int COORD_W  = 16;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int COF_W    = PROD_W + 1;
	localparam int DETP_W   = DIFF_W + COF_W;
	localparam int DET_W    = 54;
	localparam int DMAG_W   = 53;
	localparam int CMAG_W   = 33;
	localparam int DIV_W    = DMAG_W + 1;
	localparam int QUO_W    = 33;
	localparam int HI_W     = 28;
	localparam int NUM_W    = QUO_W + HI_W;
	localparam int DERIV_W  = 32;
	localparam int DERIV_SH = 25;
	localparam int LANES    = 9;
	localparam int DIFFS    = 9;

	// Each cofactor is d[A1]*d[B1] - d[A2]*d[B2] over the edge differences
	// ordered rx ry rz sx sy sz tx ty tz; the sign flips are folded into the order.
	localparam int COF_A1 [LANES] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
	localparam int COF_B1 [LANES] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
	localparam int COF_A2 [LANES] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
	localparam int COF_B2 [LANES] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [QUO_W-1:0] num;
		logic [QUO_W-1:0] quo;
		logic             ovf;
		logic             neg;
	} div_lane_t;

endpackage

FILE: design/tet_geometric_factors.sv
`timescale 1ns / 1ps
// Top level of the tetrahedron geometric factor pipeline.
// Depends on tgf_pkg for widths, cofactor index tables and the divider lane type.
//
// Usage:
// The input channel (valid/ready) carries one word per tetrahedron: the twelve
// vertex coordinates in signed Q7.8. The output channel carries one word per
// tetrahedron: the exact Jacobian determinant (Q29.24), nine inverse-Jacobian
// entries (Q14.17, saturating) and a singular flag that is set when the
// determinant is zero, in which case all derivatives read as zero.
// From acceptance to a valid output, each word passes through seven arithmetic
// stages (differences, products, cofactors, determinant partials, determinant
// sum, magnitudes, divider setup), 33 restoring-division stages producing one
// quotient bit each, and the saturating output register.
// Throughput is one word per cycle unless the output stalls; the nine divisions run
// in parallel lanes and the bit-per-stage divider chain sets the depth.
// Reset clears every valid bit; payload registers are not reset.
// When the receiver stalls, the whole pipeline holds in place and ready drops,
// so no word is lost or repeated; bubbles are filled while the output is empty.
module tet_geometric_factors (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v0_x,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v0_y,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v0_z,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v1_x,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v1_y,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v1_z,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v2_x,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v2_y,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v2_z,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v3_x,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v3_y,
	input  logic signed [tgf_pkg::COORD_W-1:0]   v3_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [tgf_pkg::DET_W-1:0]     jac_det,
	output logic signed [tgf_pkg::DERIV_W-1:0]   dr_dx,
	output logic signed [tgf_pkg::DERIV_W-1:0]   dr_dy,
	output logic signed [tgf_pkg::DERIV_W-1:0]   dr_dz,
	output logic signed [tgf_pkg::DERIV_W-1:0]   ds_dx,
	output logic signed [tgf_pkg::DERIV_W-1:0]   ds_dy,
	output logic signed [tgf_pkg::DERIV_W-1:0]   ds_dz,
	output logic signed [tgf_pkg::DERIV_W-1:0]   dt_dx,
	output logic signed [tgf_pkg::DERIV_W-1:0]   dt_dy,
	output logic signed [tgf_pkg::DERIV_W-1:0]   dt_dz,
	output logic                                 singular
);
	import tgf_pkg::*;

	// The pipeline moves as one: it advances whenever the output register is
	// empty or is being taken this cycle.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: edge differences from vertex 0.
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] d_s1 [DIFFS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= DIFF_W'(v1_x) - DIFF_W'(v0_x);
			d_s1[1] <= DIFF_W'(v1_y) - DIFF_W'(v0_y);
			d_s1[2] <= DIFF_W'(v1_z) - DIFF_W'(v0_z);
			d_s1[3] <= DIFF_W'(v2_x) - DIFF_W'(v0_x);
			d_s1[4] <= DIFF_W'(v2_y) - DIFF_W'(v0_y);
			d_s1[5] <= DIFF_W'(v2_z) - DIFF_W'(v0_z);
			d_s1[6] <= DIFF_W'(v3_x) - DIFF_W'(v0_x);
			d_s1[7] <= DIFF_W'(v3_y) - DIFF_W'(v0_y);
			d_s1[8] <= DIFF_W'(v3_z) - DIFF_W'(v0_z);
		end
	end

	// Stage 2: the eighteen 2x2 products, plus the first column carried on.
	logic                     vld_s2;
	logic signed [PROD_W-1:0] pa_s2 [LANES];
	logic signed [PROD_W-1:0] pb_s2 [LANES];
	logic signed [DIFF_W-1:0] r_s2  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++) begin
				pa_s2[k] <= d_s1[COF_A1[k]] * d_s1[COF_B1[k]];
				pb_s2[k] <= d_s1[COF_A2[k]] * d_s1[COF_B2[k]];
			end
			for (int k = 0; k < 3; k++) begin
				r_s2[k] <= d_s1[k];
			end
		end
	end

	// Stage 3: signed cofactors.
	logic                     vld_s3;
	logic signed [COF_W-1:0]  cof_s3 [LANES];
	logic signed [DIFF_W-1:0] r_s3   [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++) begin
				cof_s3[k] <= COF_W'(pa_s2[k]) - COF_W'(pb_s2[k]);
			end
			r_s3 <= r_s2;
		end
	end

	// Stage 4: determinant partial products along the first column.
	logic                     vld_s4;
	logic signed [DETP_W-1:0] dp_s4  [3];
	logic signed [COF_W-1:0]  cof_s4 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				dp_s4[k] <= r_s3[k] * cof_s3[k];
			end
			cof_s4 <= cof_s3;
		end
	end

	// Stage 5: determinant sum.
	logic                    vld_s5;
	logic signed [DET_W-1:0] det_s5;
	logic signed [COF_W-1:0] cof_s5 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s5 <= DET_W'(dp_s4[0]) + DET_W'(dp_s4[1]) + DET_W'(dp_s4[2]);
			cof_s5 <= cof_s4;
		end
	end

	// Stage 6: magnitudes and quotient signs.
	logic                    vld_s6;
	logic signed [DET_W-1:0] det_s6;
	logic [DMAG_W-1:0]       dmag_s6;
	logic [CMAG_W-1:0]       cmag_s6 [LANES];
	logic                    neg_s6  [LANES];
	logic [DET_W-1:0]        det_abs;
	logic [COF_W-1:0]        cof_abs [LANES];

	always_comb begin
		det_abs = det_s5[DET_W-1] ? DET_W'(-det_s5) : DET_W'(det_s5);
		for (int k = 0; k < LANES; k++) begin
			cof_abs[k] = cof_s5[k][COF_W-1] ? COF_W'(-cof_s5[k]) : COF_W'(cof_s5[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s6  <= det_s5;
			dmag_s6 <= det_abs[DMAG_W-1:0];
			for (int k = 0; k < LANES; k++) begin
				cmag_s6[k] <= cof_abs[k][CMAG_W-1:0];
				neg_s6[k]  <= cof_s5[k][COF_W-1] ^ det_s5[DET_W-1];
			end
		end
	end

	// Stage 7: divider setup. Rounding to nearest is folded in by dividing
	// 2n + d by 2d; a high part at or above the divisor means the quotient
	// needs more than 33 bits and will saturate.
	logic [NUM_W-1:0] numer [LANES];
	logic [DIV_W-1:0] dsor;

	always_comb begin
		dsor = {dmag_s6, 1'b0};
		for (int k = 0; k < LANES; k++) begin
			numer[k] = (NUM_W'(cmag_s6[k]) << (DERIV_SH + 1)) + NUM_W'(dmag_s6);
		end
	end

	localparam int DIV_STAGES = QUO_W;

	logic                    vld_dv  [DIV_STAGES+1];
	logic signed [DET_W-1:0] det_dv  [DIV_STAGES+1];
	logic [DIV_W-1:0]        dsor_dv [DIV_STAGES+1];
	div_lane_t               lane_dv [DIV_STAGES+1][LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dv[0] <= 1'b0;
		end else if (adv) begin
			vld_dv[0] <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_dv[0]  <= det_s6;
			dsor_dv[0] <= dsor;
			for (int k = 0; k < LANES; k++) begin
				lane_dv[0][k].rem <= DIV_W'(numer[k][NUM_W-1:QUO_W]);
				lane_dv[0][k].num <= numer[k][QUO_W-1:0];
				lane_dv[0][k].quo <= '0;
				lane_dv[0][k].ovf <= DIV_W'(numer[k][NUM_W-1:QUO_W]) >= dsor;
				lane_dv[0][k].neg <= neg_s6[k];
			end
		end
	end

	// Restoring division, one quotient bit per stage in every lane.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		logic [DIV_W:0]   trial [LANES];
		logic             take  [LANES];
		logic [DIV_W-1:0] rnext [LANES];

		always_comb begin
			for (int k = 0; k < LANES; k++) begin
				trial[k] = {lane_dv[g][k].rem, lane_dv[g][k].num[QUO_W-1]};
				take[k]  = trial[k] >= {1'b0, dsor_dv[g]};
				rnext[k] = take[k] ? DIV_W'(trial[k] - {1'b0, dsor_dv[g]})
				                   : DIV_W'(trial[k]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv[g+1] <= 1'b0;
			end else if (adv) begin
				vld_dv[g+1] <= vld_dv[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				det_dv[g+1]  <= det_dv[g];
				dsor_dv[g+1] <= dsor_dv[g];
				for (int k = 0; k < LANES; k++) begin
					lane_dv[g+1][k].rem <= rnext[k];
					lane_dv[g+1][k].num <= {lane_dv[g][k].num[QUO_W-2:0], 1'b0};
					lane_dv[g+1][k].quo <= {lane_dv[g][k].quo[QUO_W-2:0], take[k]};
					lane_dv[g+1][k].ovf <= lane_dv[g][k].ovf;
					lane_dv[g+1][k].neg <= lane_dv[g][k].neg;
				end
			end
		end
	end

	// Output register: sign, saturation, and the singular case.
	localparam logic [QUO_W-1:0] POS_LIM = QUO_W'({1'b0, {(DERIV_W-1){1'b1}}});
	localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'({1'b1, {(DERIV_W-1){1'b0}}});

	div_lane_t                 fin [LANES];
	logic signed [DERIV_W-1:0] res [LANES];
	logic                      sing;

	always_comb begin
		fin  = lane_dv[DIV_STAGES];
		sing = det_dv[DIV_STAGES] == '0;
		for (int k = 0; k < LANES; k++) begin
			if (sing) begin
				res[k] = '0;
			end else if (fin[k].neg) begin
				res[k] = (fin[k].ovf || fin[k].quo > NEG_LIM) ? DERIV_W'(NEG_LIM)
				                                               : DERIV_W'(-fin[k].quo);
			end else begin
				res[k] = (fin[k].ovf || fin[k].quo > POS_LIM) ? DERIV_W'(POS_LIM)
				                                               : DERIV_W'(fin[k].quo);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_dv[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			jac_det  <= det_dv[DIV_STAGES];
			singular <= sing;
			dr_dx    <= res[0];
			dr_dy    <= res[1];
			dr_dz    <= res[2];
			ds_dx    <= res[3];
			ds_dy    <= res[4];
			ds_dz    <= res[5];
			dt_dx    <= res[6];
			dt_dy    <= res[7];
			dt_dz    <= res[8];
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tet_geometric_factors: drives tetrahedra, predicts
// determinant and inverse-Jacobian entries, and checks every output word in order.
// Depends on tgf_pkg and the tet_geometric_factors RTL.

// Expected output word of the block.
typedef struct {
	logic signed [53:0] det;
	logic signed [31:0] der [9];
	logic               sing;
} geo_word_t;

// Keeps the predicted words in acceptance order and compares the block's output.
class geo_scoreboard;
	geo_word_t pending [$];
	int        errors;
	int        checked;
	int        singular_seen;
	int        clamped_seen;

	// Rounded (half away from zero) and saturated cof * 2^25 / det.
	function logic signed [31:0] ratio_q16(longint cof, longint det);
		logic [127:0] n, d, q;
		bit neg;
		n = (cof < 0 ? -cof : cof);
		n = n << 25;
		d = (det < 0 ? -det : det);
		q = (2 * n + d) / (2 * d);
		neg = (cof < 0) != (det < 0);
		if (neg) begin
			if (q > 128'h8000_0000) return 32'sh8000_0000;
			return -$signed(q[32:0]);
		end
		if (q > 128'h7fff_ffff) return 32'sh7fff_ffff;
		return q[31:0];
	endfunction

	// Note an accepted tetrahedron; v holds x,y,z for vertices 0..3.
	function void note_tet(logic signed [15:0] v [12]);
		geo_word_t w;
		longint e [9];
		longint c [9];
		longint det;
		for (int i = 0; i < 9; i++) e[i] = longint'(v[3 + i]) - longint'(v[i % 3]);
		// e = rx ry rz sx sy sz tx ty tz
		c[0] = e[4] * e[8] - e[5] * e[7];
		c[1] = -(e[3] * e[8] - e[5] * e[6]);
		c[2] = e[3] * e[7] - e[4] * e[6];
		c[3] = -(e[1] * e[8] - e[2] * e[7]);
		c[4] = e[0] * e[8] - e[2] * e[6];
		c[5] = -(e[0] * e[7] - e[1] * e[6]);
		c[6] = e[1] * e[5] - e[2] * e[4];
		c[7] = -(e[0] * e[5] - e[2] * e[3]);
		c[8] = e[0] * e[4] - e[1] * e[3];
		det = e[0] * c[0] + e[1] * c[1] + e[2] * c[2];
		w.det = det[53:0];
		w.sing = (det == 0);
		for (int i = 0; i < 9; i++) begin
			w.der[i] = w.sing ? 32'sd0 : ratio_q16(c[i], det);
			if (!w.sing && (w.der[i] == 32'sh7fff_ffff || w.der[i] == 32'sh8000_0000))
				clamped_seen++;
		end
		if (w.sing) singular_seen++;
		pending.push_back(w);
	endfunction

	// Compare one output word against the oldest prediction.
	function void check_word(geo_word_t got);
		geo_word_t w;
		string nm [9] = '{"dr_dx", "dr_dy", "dr_dz", "ds_dx", "ds_dy", "ds_dz",
			"dt_dx", "dt_dy", "dt_dz"};
		if (pending.size() == 0) begin
			$error("output word with no prediction waiting");
			errors++;
			return;
		end
		w = pending.pop_front();
		checked++;
		if (got.det !== w.det) begin
			$error("jac_det: expected %0d, got %0d", w.det, got.det);
			errors++;
		end
		for (int i = 0; i < 9; i++)
			if (got.der[i] !== w.der[i]) begin
				$error("%s: expected %0d, got %0d", nm[i], w.der[i], got.der[i]);
				errors++;
			end
		if (got.sing !== w.sing) begin
			$error("singular: expected %0d, got %0d", w.sing, got.sing);
			errors++;
		end
	endfunction
endclass

module tb;
	import tgf_pkg::*;

	localparam int LATENCY    = 41;
	localparam int N_RANDOM   = 800;
	localparam int STALL_LONG = 150;
	localparam int WATCHDOG   = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [COORD_W-1:0] vtx [12];
	logic signed [DET_W-1:0] jac_det;
	logic signed [DERIV_W-1:0] dr_dx, dr_dy, dr_dz, ds_dx, ds_dy, ds_dz;
	logic signed [DERIV_W-1:0] dt_dx, dt_dy, dt_dz;
	logic singular;

	geo_scoreboard board = new();
	bit  feed_done = 1'b0;
	int  idle_cycles = 0;
	int  sent = 0;

	initial for (int i = 0; i < 12; i++) vtx[i] = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tet_geometric_factors u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.v0_x(vtx[0]), .v0_y(vtx[1]), .v0_z(vtx[2]),
		.v1_x(vtx[3]), .v1_y(vtx[4]), .v1_z(vtx[5]),
		.v2_x(vtx[6]), .v2_y(vtx[7]), .v2_z(vtx[8]),
		.v3_x(vtx[9]), .v3_y(vtx[10]), .v3_z(vtx[11]),
		.out_valid(out_valid), .out_ready(out_ready),
		.jac_det(jac_det),
		.dr_dx(dr_dx), .dr_dy(dr_dy), .dr_dz(dr_dz),
		.ds_dx(ds_dx), .ds_dy(ds_dy), .ds_dz(ds_dz),
		.dt_dx(dt_dx), .dt_dy(dt_dy), .dt_dz(dt_dz),
		.singular(singular)
	);

	// Gap length: mostly none or short, now and then a long one.
	function int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Offer one word and hold it until the block takes it. The valid stays high
	// across back-to-back words, so it is only lowered when a gap follows.
	task automatic send_tet(logic signed [15:0] v [12]);
		int gap;
		in_valid <= 1'b1;
		for (int i = 0; i < 12; i++) vtx[i] <= v[i];
		do @(posedge clk); while (!in_ready);
		board.note_tet(v);
		sent++;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random coordinate: full range, small values and the two extremes.
	function logic signed [15:0] rand_coord(int style);
		int p;
		p = $urandom_range(99);
		if (style == 0 || p < 10) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		if (style == 1) return $signed(16'($urandom_range(0, 16'hffff)));
		return $signed(16'($urandom_range(0, 31))) - 16'sd16;
	endfunction

	task automatic random_tet();
		logic signed [15:0] v [12];
		int kind;
		int style;
		kind = $urandom_range(99);
		style = $urandom_range(1, 2);
		for (int i = 0; i < 12; i++) v[i] = rand_coord(style);
		if (kind < 6) begin
			// Degenerate: vertex 3 repeats vertex 1.
			for (int i = 0; i < 3; i++) v[9 + i] = v[3 + i];
		end else if (kind < 10) begin
			// Coplanar: vertex 3 = v1 + v2 - v0 computed in small coordinates.
			for (int i = 0; i < 3; i++) begin
				v[i] = rand_coord(2);
				v[3 + i] = rand_coord(2);
				v[6 + i] = rand_coord(2);
				v[9 + i] = v[3 + i] + v[6 + i] - v[i];
			end
		end else if (kind < 20) begin
			// Thin element: tiny determinant against big cofactors, drives clamping.
			for (int i = 0; i < 12; i++) v[i] = rand_coord(1);
			for (int i = 0; i < 3; i++) v[9 + i] = v[3 + i] + $signed(2'($urandom_range(0, 3)));
		end
		send_tet(v);
	endtask

	task automatic directed_tets();
		logic signed [15:0] v [12];
		// Unit tetrahedron, positive and mirrored (negative determinant).
		v = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256};
		send_tet(v);
		v = '{0, 0, 0, 0, 256, 0, 256, 0, 0, 0, 0, 256};
		send_tet(v);
		// Smallest nonzero edges, plain and mirrored: large derivatives of both signs.
		v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_tet(v);
		v = '{0, 0, 0, -1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_tet(v);
		// All vertices equal: zero determinant.
		v = '{5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5};
		send_tet(v);
		v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
		send_tet(v);
		// Largest edges: determinant near its full range, both signs.
		v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff};
		send_tet(v);
		v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000};
		send_tet(v);
		v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
		send_tet(v);
		// Collinear vertices: zero determinant with nonzero edges.
		v = '{0, 0, 0, 100, 200, 300, 200, 400, 600, 16'sh7fff, 0, 16'sh8000};
		send_tet(v);
		// Alternating bit masks on every field, then their complements.
		v = '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
			16'sh0f0f, 16'shf0f0, 16'sh00ff, 16'shff00, 16'sh3333, 16'shcccc};
		send_tet(v);
		v = '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
			16'shf0f0, 16'sh0f0f, 16'shff00, 16'sh00ff, 16'shcccc, 16'sh3333};
		send_tet(v);
		// Rounding: determinants 3 and 5, which leave remainders to round.
		v = '{0, 0, 0, 3, 0, 0, 0, 1, 0, 0, 0, 1};
		send_tet(v);
		v = '{0, 0, 0, 1, 1, 0, 0, 2, 1, 1, 0, 2};
		send_tet(v);
	endtask

	// Sender: directed words, a pause until the pipe drains, then random words.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_tets();
		in_valid <= 1'b0;
		// Pause with nothing offered until every predicted word is back.
		while (board.pending.size() != 0) @(posedge clk);
		for (int n = 0; n < N_RANDOM; n++) random_tet();
		in_valid <= 1'b0;
		feed_done = 1'b1;
	end

	// Receiver: random backpressure plus one long hold-off while the sender keeps
	// offering words, so the pipeline holds in place and in_ready drops.
	initial begin
		int gap;
		bit stalled_once;
		stalled_once = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!stalled_once && sent > 200) begin
				stalled_once = 1'b1;
				out_ready <= 1'b0;
				repeat (STALL_LONG) @(posedge clk);
			end
			gap = gap_len();
			if (gap > 0 && $urandom_range(99) < 40) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Output monitor: sample at the rising edge, before the nonblocking updates land.
	always @(posedge clk) begin
		geo_word_t got;
		if (arst_n && out_valid && out_ready) begin
			got.det = jac_det;
			got.der = '{dr_dx, dr_dy, dr_dz, ds_dx, ds_dy, ds_dz, dt_dx, dt_dy, dt_dz};
			got.sing = singular;
			board.check_word(got);
		end
	end

	// Watchdog on cycles with no accepted word on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog: no progress for %0d cycles", WATCHDOG);
				$display("RESULT: ERROR");
				$finish;
			end
			if (feed_done && board.pending.size() == 0) begin
				// Let any stray extra word show up before closing.
				repeat (LATENCY + 20) @(posedge clk);
				$display("Checked %0d tetrahedra, %0d singular, %0d clamped derivatives.",
					board.checked, board.singular_seen, board.clamped_seen);
				if (board.errors == 0 && board.pending.size() == 0)
					$display("RESULT: OK");
				else
					$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule

FILE: tet_geometric_factors.f
design/tgf_pkg.sv
design/tet_geometric_factors.sv
tb/tb.sv
